FILE: sv/odfe_pkg.sv
// Shared types, tables and helper functions of the OFDM data field encoder.
package odfe_pkg;

   localparam int MAX_SYMBOL_BITS_DEF = 288;
   localparam int WORD_BITS           = 48;
   localparam int ROW_BITS            = 3;
   localparam int COL_BITS            = 6;
   localparam int POS_BITS            = 9;

   localparam logic [6:0]  SEED_RESET  = 7'd93;
   localparam logic [2:0]  RATE_RESET  = 3'd0;
   localparam logic [17:0] PAT_R34     = 18'h18618;
   localparam logic [11:0] PAT_R23     = 12'h888;
   localparam logic        CSR_IDX_SEED = 1'b0;
   localparam logic        CSR_IDX_RATE = 1'b1;

   localparam logic [1:0] PUNC_NONE = 2'd0;
   localparam logic [1:0] PUNC_R34  = 2'd1;
   localparam logic [1:0] PUNC_R23  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_READ,
      ST_LOAD
   } odfe_state_type;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_SERVICE,
      PH_DATA,
      PH_TAIL,
      PH_PAD
   } odfe_phase_type;

   typedef struct packed {
      logic                we;
      logic [POS_BITS-1:0] pos;
      logic                wbit;
   } odfe_mem_wr_type;

   typedef struct packed {
      logic                re;
      logic [ROW_BITS-1:0] row;
   } odfe_mem_rd_type;

   function automatic logic [7:0] dbps(input logic [2:0] mode);
      logic [7:0] r;
      case (mode)
         3'd0:    r = 8'd24;
         3'd1:    r = 8'd36;
         3'd2:    r = 8'd48;
         3'd3:    r = 8'd72;
         3'd4:    r = 8'd96;
         3'd5:    r = 8'd144;
         3'd6:    r = 8'd192;
         default: r = 8'd216;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] cbps(input logic [2:0] mode);
      logic [8:0] r;
      case (mode[2:1])
         2'd0:    r = 9'd48;
         2'd1:    r = 9'd96;
         2'd2:    r = 9'd192;
         default: r = 9'd288;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] words_per_symbol(input logic [2:0] mode);
      logic [2:0] r;
      case (mode[2:1])
         2'd0:    r = 3'd1;
         2'd1:    r = 3'd2;
         2'd2:    r = 3'd4;
         default: r = 3'd6;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] punc_kind(input logic [2:0] mode);
      logic [1:0] r;
      case (mode)
         3'd1, 3'd3, 3'd5, 3'd7: r = PUNC_R34;
         3'd6:                   r = PUNC_R23;
         default:                r = PUNC_NONE;
      endcase
      return r;
   endfunction

   // Interleaved position of coded bit k within a symbol.
   function automatic logic [8:0] interleave_pos(input logic [8:0] k, input logic [2:0] mode);
      logic [3:0] m;
      logic [4:0] q;
      logic [4:0] n;
      logic [8:0] i;
      logic [8:0] qm;
      logic [7:0] mm;
      logic [2:0] qd;
      logic [2:0] md;
      logic [4:0] qt;
      logic [3:0] mt;
      logic [2:0] t;
      logic [1:0] r;
      logic [8:0] p;
      m  = k[3:0];
      q  = k[8:4];
      case (mode[2:1])
         2'd0:    n = 5'd3;
         2'd1:    n = 5'd6;
         2'd2:    n = 5'd12;
         default: n = 5'd18;
      endcase
      i  = 9'(n) * 9'(m) + 9'(q);
      qm = 9'(q) * 9'd11;
      mm = 8'(m) * 8'd11;
      qd = qm[7:5];
      md = mm[7:5];
      qt = q - 5'(qd) * 5'd3;
      mt = m - 4'(md) * 4'd3;
      t  = 3'(qt[1:0]) + 3'd3 - 3'(mt[1:0]);
      r  = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
      case (mode[2:1])
         2'd2:    p = {i[8:1], i[0] ^ m[0]};
         2'd3:    p = 9'(m) * 9'd18 + 9'(qd) * 9'd3 + 9'(r);
         default: p = i;
      endcase
      return p;
   endfunction

   function automatic logic [ROW_BITS-1:0] pos_row(input logic [8:0] p);
      logic [ROW_BITS-1:0] r;
      if (p >= 9'd240) begin
         r = 3'd5;
      end else if (p >= 9'd192) begin
         r = 3'd4;
      end else if (p >= 9'd144) begin
         r = 3'd3;
      end else if (p >= 9'd96) begin
         r = 3'd2;
      end else if (p >= 9'd48) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

endpackage

FILE: sv/ofdm_data_field_encoder_core.sv
// Top level of the OFDM data field encoder: scrambler, coder, puncturer, interleaver.
// The two coded bits of each data bit are handled one after the other, because the
// symbol store has a single write port; the first byte of a packet is preceded by the
// 16 service bits, and the last byte is followed by the 6 tail bits and any pad bits.
// When a symbol is complete, the store is drained word by word (1, 2, 4 or 6 48-bit
// words), each word read and then loaded into the result register, before coding
// continues; a load waits while the result side stalls.
// A new byte is taken only when the previous one is fully coded.
module ofdm_data_field_encoder_core #(
   parameter int MAX_SYMBOL_BITS = odfe_pkg::MAX_SYMBOL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // coded_word
   output logic        rsp_tuser,   // end_of_symbol
   output logic        rsp_tlast,   // end_of_packet
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   odfe_pkg::odfe_state_type state_ff, state_in;
   odfe_pkg::odfe_phase_type phase_ff, phase_in;
   logic        sub_ff, sub_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        in_packet_ff, in_packet_in;
   logic [6:0]  scr_ff, scr_in;
   logic [5:0]  hist_ff, hist_in;
   logic [7:0]  data_cnt_ff, data_cnt_in;
   logic [4:0]  punc_ff, punc_in;
   logic [8:0]  coded_cnt_ff, coded_cnt_in;
   logic        c_bit_ff, c_bit_in;
   logic [2:0]  word_ff, word_in;
   logic        eop_pend_ff, eop_pend_in;
   logic [6:0]  seed_ff, seed_in;
   logic [2:0]  rate_ff, rate_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_eos_ff, rsp_eos_in;
   logic        rsp_eop_ff, rsp_eop_in;

   odfe_pkg::odfe_mem_wr_type mem_wr;
   odfe_pkg::odfe_mem_rd_type mem_rd;
   logic [47:0] mem_rdata;

   logic       accept, run, csr_write;
   logic       fb, b, a_bit, c_bit, src, keep, wr, sym_done, wrap, pkt_end_bit;
   logic       out_free, load_out, last_word;
   logic [1:0] kind;
   logic [4:0] punc_next;
   logic [7:0] dbps_v;
   logic [8:0] cbps_v;
   logic [2:0] nwords;

   odfe_symbol_mem #(.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)) u_mem (
      .clock (clock),
      .wr    (mem_wr),
      .rd    (mem_rd),
      .rdata (mem_rdata)
   );

   always_comb begin
      dbps_v = odfe_pkg::dbps(rate_ff);
      cbps_v = odfe_pkg::cbps(rate_ff);
      nwords = odfe_pkg::words_per_symbol(rate_ff);
      kind   = odfe_pkg::punc_kind(rate_ff);
      fb     = scr_ff[3] ^ scr_ff[6];
      src    = (phase_ff == odfe_pkg::PH_DATA) ? byte_ff[bit_cnt_ff[2:0]] : 1'b0;
      b      = (phase_ff == odfe_pkg::PH_TAIL) ? 1'b0 : (src ^ fb);
      a_bit  = b ^ hist_ff[1] ^ hist_ff[2] ^ hist_ff[4] ^ hist_ff[5];
      c_bit  = b ^ hist_ff[0] ^ hist_ff[1] ^ hist_ff[2] ^ hist_ff[5];
      case (kind)
         odfe_pkg::PUNC_R34: begin
            keep      = !odfe_pkg::PAT_R34[punc_ff];
            punc_next = (punc_ff == 5'd17) ? 5'd0 : punc_ff + 5'd1;
         end
         odfe_pkg::PUNC_R23: begin
            keep      = !odfe_pkg::PAT_R23[punc_ff[3:0]];
            punc_next = (punc_ff == 5'd11) ? 5'd0 : punc_ff + 5'd1;
         end
         default: begin
            keep      = 1'b1;
            punc_next = punc_ff;
         end
      endcase
      run         = (state_ff == odfe_pkg::ST_RUN);
      wr          = run && keep;
      sym_done    = wr && (coded_cnt_ff == cbps_v - 9'd1);
      wrap        = (data_cnt_ff == dbps_v - 8'd1);
      pkt_end_bit = wrap && ((phase_ff == odfe_pkg::PH_PAD) ||
                             ((phase_ff == odfe_pkg::PH_TAIL) && (bit_cnt_ff == 4'd5)));
      out_free    = !rsp_valid_ff || rsp_tready;
      last_word   = (word_ff == nwords - 3'd1);
      accept      = req_tvalid && req_tready;
      csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         odfe_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = odfe_pkg::ST_RUN;
            end
         end
         odfe_pkg::ST_RUN: begin
            if (sym_done) begin
               state_in = odfe_pkg::ST_READ;
            end else if (sub_ff && (phase_in == odfe_pkg::PH_NONE)) begin
               state_in = odfe_pkg::ST_IDLE;
            end
         end
         odfe_pkg::ST_READ: begin
            state_in = odfe_pkg::ST_LOAD;
         end
         odfe_pkg::ST_LOAD: begin
            if (out_free) begin
               if (!last_word) begin
                  state_in = odfe_pkg::ST_READ;
               end else if (phase_ff == odfe_pkg::PH_NONE) begin
                  state_in = odfe_pkg::ST_IDLE;
               end else begin
                  state_in = odfe_pkg::ST_RUN;
               end
            end
         end
         default: state_in = odfe_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_tready  = (state_ff == odfe_pkg::ST_IDLE);
      load_out    = (state_ff == odfe_pkg::ST_LOAD) && out_free;
      mem_rd.re   = (state_ff == odfe_pkg::ST_READ);
      mem_rd.row  = word_ff;
      mem_wr.we   = wr;
      mem_wr.pos  = odfe_pkg::interleave_pos(coded_cnt_ff, rate_ff);
      mem_wr.wbit = sub_ff ? c_bit_ff : a_bit;
   end

   // Datapath next values.
   always_comb begin
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      bit_cnt_in   = bit_cnt_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      in_packet_in = in_packet_ff;
      scr_in       = scr_ff;
      hist_in      = hist_ff;
      data_cnt_in  = data_cnt_ff;
      punc_in      = punc_ff;
      coded_cnt_in = coded_cnt_ff;
      c_bit_in     = c_bit_ff;
      word_in      = word_ff;
      eop_pend_in  = eop_pend_ff;
      seed_in      = seed_ff;
      rate_in      = rate_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_eos_in   = rsp_eos_ff;
      rsp_eop_in   = rsp_eop_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (csr_write) begin
         if (csr_paddr[2] == odfe_pkg::CSR_IDX_SEED) begin
            seed_in = csr_pwdata[6:0];
         end else if (!in_packet_ff) begin
            rate_in = csr_pwdata[2:0];
         end
      end

      if (accept) begin
         byte_in    = req_tdata;
         last_in    = req_tlast;
         sub_in     = 1'b0;
         bit_cnt_in = 4'd0;
         if (in_packet_ff) begin
            phase_in = odfe_pkg::PH_DATA;
         end else begin
            phase_in     = odfe_pkg::PH_SERVICE;
            in_packet_in = 1'b1;
            scr_in       = seed_ff;
            hist_in      = '0;
            data_cnt_in  = '0;
            punc_in      = '0;
            coded_cnt_in = '0;
         end
      end

      if (run) begin
         punc_in = punc_next;
         if (wr) begin
            coded_cnt_in = sym_done ? 9'd0 : coded_cnt_ff + 9'd1;
         end
         if (sym_done) begin
            word_in     = 3'd0;
            eop_pend_in = pkt_end_bit;
         end
         if (!sub_ff) begin
            scr_in   = {scr_ff[5:0], fb};
            hist_in  = {hist_ff[4:0], b};
            c_bit_in = c_bit;
            sub_in   = 1'b1;
         end else begin
            sub_in      = 1'b0;
            data_cnt_in = wrap ? 8'd0 : data_cnt_ff + 8'd1;
            bit_cnt_in  = bit_cnt_ff + 4'd1;
            case (phase_ff)
               odfe_pkg::PH_SERVICE: begin
                  if (bit_cnt_ff == 4'd15) begin
                     phase_in   = odfe_pkg::PH_DATA;
                     bit_cnt_in = 4'd0;
                  end
               end
               odfe_pkg::PH_DATA: begin
                  if (bit_cnt_ff == 4'd7) begin
                     phase_in   = last_ff ? odfe_pkg::PH_TAIL : odfe_pkg::PH_NONE;
                     bit_cnt_in = 4'd0;
                  end
               end
               odfe_pkg::PH_TAIL: begin
                  if (bit_cnt_ff == 4'd5) begin
                     bit_cnt_in = 4'd0;
                     if (wrap) begin
                        phase_in     = odfe_pkg::PH_NONE;
                        in_packet_in = 1'b0;
                     end else begin
                        phase_in = odfe_pkg::PH_PAD;
                     end
                  end
               end
               odfe_pkg::PH_PAD: begin
                  if (wrap) begin
                     phase_in     = odfe_pkg::PH_NONE;
                     in_packet_in = 1'b0;
                  end
               end
               default: phase_in = odfe_pkg::PH_NONE;
            endcase
         end
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mem_rdata;
         rsp_eos_in   = last_word;
         rsp_eop_in   = last_word && eop_pend_ff;
         if (!last_word) begin
            word_in = word_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= odfe_pkg::ST_IDLE;
         phase_ff     <= odfe_pkg::PH_NONE;
         sub_ff       <= 1'b0;
         in_packet_ff <= 1'b0;
         seed_ff      <= odfe_pkg::SEED_RESET;
         rate_ff      <= odfe_pkg::RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         in_packet_ff <= in_packet_in;
         seed_ff      <= seed_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff   <= bit_cnt_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      scr_ff       <= scr_in;
      hist_ff      <= hist_in;
      data_cnt_ff  <= data_cnt_in;
      punc_ff      <= punc_in;
      coded_cnt_ff <= coded_cnt_in;
      c_bit_ff     <= c_bit_in;
      word_ff      <= word_in;
      eop_pend_ff  <= eop_pend_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_eos_ff   <= rsp_eos_in;
      rsp_eop_ff   <= rsp_eop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_eos_ff;
   assign rsp_tlast  = rsp_eop_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == odfe_pkg::CSR_IDX_RATE) ? {29'd0, rate_ff}
                                                                 : {25'd0, seed_ff};

endmodule

FILE: sv/odfe_symbol_mem.sv
// Symbol store: interleaved coded bits written one at a time, read as 48-bit rows.
module odfe_symbol_mem #(
   parameter int MAX_SYMBOL_BITS = odfe_pkg::MAX_SYMBOL_BITS_DEF
) (
   input  logic                             clock,
   input  odfe_pkg::odfe_mem_wr_type        wr,
   input  odfe_pkg::odfe_mem_rd_type        rd,
   output logic [odfe_pkg::WORD_BITS-1:0]   rdata
);
   localparam int NROWS = (MAX_SYMBOL_BITS + odfe_pkg::WORD_BITS - 1) / odfe_pkg::WORD_BITS;
   localparam int IDX_W = (NROWS > 1) ? $clog2(NROWS) : 1;

   logic [odfe_pkg::WORD_BITS-1:0] mem [NROWS];
   logic [odfe_pkg::WORD_BITS-1:0] rdata_ff;
   logic [odfe_pkg::WORD_BITS-1:0] mask;
   logic [odfe_pkg::ROW_BITS-1:0]  wrow;
   logic [odfe_pkg::COL_BITS-1:0]  wcol;
   logic [9:0]                     base;

   always_comb begin
      wrow = odfe_pkg::pos_row(wr.pos);
      wcol = odfe_pkg::COL_BITS'(wr.pos - 9'(wrow) * 9'd48);
      base = 10'(rd.row) * 10'd48;
      for (int j = 0; j < odfe_pkg::WORD_BITS; j++) begin
         mask[j] = (base + 10'(j)) < 10'(MAX_SYMBOL_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we && (10'(wr.pos) < 10'(MAX_SYMBOL_BITS))) begin
         mem[wrow[IDX_W-1:0]][wcol] <= wr.wbit;
      end
      if (rd.re) begin
         if (4'(rd.row) < 4'(NROWS)) begin
            rdata_ff <= mem[rd.row[IDX_W-1:0]] & mask;
         end else begin
            rdata_ff <= '0;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/odfe_checker.sv
// Port-level assertions for the OFDM data field encoder and their bind.
module odfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

   a_packet_end_on_symbol_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tlast || rsp_tuser)
      else $error("packet end not on a symbol end");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a byte is being coded");

endmodule

bind ofdm_data_field_encoder_core odfe_checker u_odfe_checker (.*);
